/* rtl/tps_pkg.sv */
package tps_pkg;
  localparam int COORD_BITS_DEF = 32;

  typedef struct packed {
    logic en;
  } tps_ctrl_t;
endpackage

/* rtl/tps_interp.sv */
module tps_interp #(
  parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  tps_pkg::tps_ctrl_t           ctrl,
  input  logic signed [COORD_BITS-1:0] p0,
  input  logic signed [COORD_BITS:0]   dp,
  input  logic signed [COORD_BITS:0]   num,
  input  logic signed [COORD_BITS:0]   den,
  output logic signed [COORD_BITS-1:0] res
);
  import tps_pkg::*;

  localparam int M  = COORD_BITS + 1;
  localparam int H  = M / 2;
  localparam int MH = M - H;

  logic [M-1:0]          s1_mn, s1_md, s1_mden;
  logic                  s1_neg, s2_neg, s3_neg;
  logic [COORD_BITS-1:0] s1_p0, s2_p0, s3_p0;
  logic [M-1:0]          s2_den, s3_den;
  logic [M+H-1:0]        s2_pl;
  logic [M+MH-1:0]       s2_ph;
  logic [2*M-1:0]        s3_prod;

  logic [M-1:0]          rem  [0:M];
  logic [M-1:0]          low  [0:M];
  logic [M-1:0]          quo  [0:M];
  logic [M-1:0]          dd   [0:M];
  logic                  ng   [0:M];
  logic [COORD_BITS-1:0] pz   [0:M];
  logic [M-1:0]          qsum;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      s1_mn   <= num[M-1] ? M'(-num) : M'(num);
      s1_md   <= dp[M-1]  ? M'(-dp)  : M'(dp);
      s1_mden <= den[M-1] ? M'(-den) : M'(den);
      s1_neg  <= (num[M-1] ^ dp[M-1]) ^ den[M-1];
      s1_p0   <= p0;
      s2_pl   <= (M+H)'(s1_mn) * (M+H)'(s1_md[H-1:0]);
      s2_ph   <= (M+MH)'(s1_mn) * (M+MH)'(s1_md[M-1:H]);
      s2_den  <= s1_mden;
      s2_neg  <= s1_neg;
      s2_p0   <= s1_p0;
      s3_prod <= (2*M)'(s2_pl) + {s2_ph, {H{1'b0}}};
      s3_den  <= s2_den;
      s3_neg  <= s2_neg;
      s3_p0   <= s2_p0;
    end
  end

  assign rem[0] = s3_prod[2*M-1:M];
  assign low[0] = s3_prod[M-1:0];
  assign quo[0] = '0;
  assign dd[0]  = s3_den;
  assign ng[0]  = s3_neg;
  assign pz[0]  = s3_p0;

  for (genvar k = 0; k < M; k++) begin : g_div
    logic [M:0] r, diff;
    logic       ge;
    always_comb begin
      r    = {rem[k], low[k][M-1]};
      diff = r - {1'b0, dd[k]};
      ge   = r >= {1'b0, dd[k]};
    end
    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        rem[k+1] <= ge ? diff[M-1:0] : r[M-1:0];
        low[k+1] <= {low[k][M-2:0], 1'b0};
        quo[k+1] <= {quo[k][M-2:0], ge};
        dd[k+1]  <= dd[k];
        ng[k+1]  <= ng[k];
        pz[k+1]  <= pz[k];
      end
    end
  end

  assign qsum = ng[M] ? M'({pz[M][COORD_BITS-1], pz[M]}) - quo[M]
                      : M'({pz[M][COORD_BITS-1], pz[M]}) + quo[M];

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      res <= qsum[COORD_BITS-1:0];
    end
  end
endmodule

/* rtl/triangle_plane_slice_core.sv */
// Triangle / horizontal plane slice, fully pipelined.
// Stages: edge select, |x|, partial products, product sum,
// one quotient bit per stage over COORD_BITS + 1 stages, add.
// Throughput: one transaction per cycle; a stall at the output holds all stages.
// Reset (rst, synchronous) clears the stage valid bits only.
module triangle_plane_slice_core #(
  parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  input  logic signed [COORD_BITS-1:0] plane_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic signed [COORD_BITS-1:0] end_x,
  output logic signed [COORD_BITS-1:0] end_y
);
  import tps_pkg::*;

  localparam int M   = COORD_BITS + 1;
  localparam int LAT = M + 5;

  tps_ctrl_t ctrl;
  logic      vpipe [0:LAT-1];
  logic      hpipe [0:LAT-1];

  logic signed [M-1:0]          vx [0:2], vy [0:2], vz [0:2];
  logic signed [M-1:0]          z;
  logic [2:0]                   cnt;
  logic [1:0]                   e0, e1, j0, j1;
  logic                         hit_c;

  logic signed [COORD_BITS-1:0] l_p0  [0:3];
  logic signed [M-1:0]          l_dp  [0:3];
  logic signed [M-1:0]          l_num [0:3];
  logic signed [M-1:0]          l_den [0:3];
  logic signed [COORD_BITS-1:0] l_res [0:3];

  assign ctrl.en  = !(out_valid && out_stall);
  assign in_stall = !ctrl.en;

  always_comb begin
    vx[0] = M'(ax); vy[0] = M'(ay); vz[0] = M'(az);
    vx[1] = M'(bx); vy[1] = M'(by); vz[1] = M'(bz);
    vx[2] = M'(cx); vy[2] = M'(cy); vz[2] = M'(cz);
    z     = M'(plane_z);
    hit_c = ((vz[0] < z) || (vz[1] < z) || (vz[2] < z)) &&
            ((vz[0] > z) || (vz[1] > z) || (vz[2] > z));
    cnt[0] = (vz[0] < vz[1]) ? (vz[0] <= z && z < vz[1]) : (vz[1] <= z && z < vz[0]);
    cnt[1] = (vz[1] < vz[2]) ? (vz[1] <= z && z < vz[2]) : (vz[2] <= z && z < vz[1]);
    cnt[2] = (vz[2] < vz[0]) ? (vz[2] <= z && z < vz[0]) : (vz[0] <= z && z < vz[2]);
    e0 = cnt[0] ? 2'd0 : (cnt[1] ? 2'd1 : 2'd2);
    e1 = (cnt[0] && cnt[1]) ? 2'd1 : 2'd2;
    j0 = (e0 == 2'd2) ? 2'd0 : e0 + 2'd1;
    j1 = (e1 == 2'd2) ? 2'd0 : e1 + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      l_p0[0]  <= COORD_BITS'(vx[e0]);
      l_p0[1]  <= COORD_BITS'(vy[e0]);
      l_p0[2]  <= COORD_BITS'(vx[e1]);
      l_p0[3]  <= COORD_BITS'(vy[e1]);
      l_dp[0]  <= vx[j0] - vx[e0];
      l_dp[1]  <= vy[j0] - vy[e0];
      l_dp[2]  <= vx[j1] - vx[e1];
      l_dp[3]  <= vy[j1] - vy[e1];
      l_num[0] <= z - vz[e0];
      l_num[1] <= z - vz[e0];
      l_num[2] <= z - vz[e1];
      l_num[3] <= z - vz[e1];
      l_den[0] <= vz[j0] - vz[e0];
      l_den[1] <= vz[j0] - vz[e0];
      l_den[2] <= vz[j1] - vz[e1];
      l_den[3] <= vz[j1] - vz[e1];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    tps_interp #(.COORD_BITS(COORD_BITS)) u_interp (
      .clk  (clk),
      .ctrl (ctrl),
      .p0   (l_p0[i]),
      .dp   (l_dp[i]),
      .num  (l_num[i]),
      .den  (l_den[i]),
      .res  (l_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vpipe[k] <= 1'b0;
    end else if (ctrl.en) begin
      vpipe[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vpipe[k] <= vpipe[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      hpipe[0] <= hit_c;
      for (int k = 1; k < LAT; k++) hpipe[k] <= hpipe[k-1];
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign hit       = hpipe[LAT-1];
  assign start_x   = hit ? l_res[0] : '0;
  assign start_y   = hit ? l_res[1] : '0;
  assign end_x     = hit ? l_res[2] : '0;
  assign end_y     = hit ? l_res[3] : '0;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(start_x) && $stable(end_y)))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
    else $error("miss with nonzero endpoints");
endmodule

/* tb/sv/tps_slice_checker.sv */
module tps_slice_checker #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, plane_z,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                hit,
  input  logic signed [W-1:0] start_x, start_y, end_x, end_y,
  output int                  errors,
  output int                  pending
);
  typedef struct packed {
    logic           hit;
    logic [W-1:0]   sx, sy, ex, ey;
  } seg_t;

  seg_t segs_q[$];

  function automatic logic signed [W-1:0] lerp(
      logic signed [W-1:0] p0, logic signed [W-1:0] p1,
      logic signed [W-1:0] z0, logic signed [W-1:0] z1, logic signed [W-1:0] pz);
    logic signed [W+1:0]   dp, num, den;
    logic signed [2*W+3:0] prod, q;
    dp = $signed({p1[W-1], p1[W-1], p1}) - $signed({p0[W-1], p0[W-1], p0});
    num = $signed({pz[W-1], pz[W-1], pz}) - $signed({z0[W-1], z0[W-1], z0});
    den = $signed({z1[W-1], z1[W-1], z1}) - $signed({z0[W-1], z0[W-1], z0});
    prod = $signed(num) * $signed(dp);
    q = prod / $signed({{(W+2){den[W+1]}}, den});
    return W'(p0 + q);
  endfunction

  function automatic seg_t slice(
      logic signed [W-1:0] vx[3], logic signed [W-1:0] vy[3],
      logic signed [W-1:0] vz[3], logic signed [W-1:0] pz);
    seg_t r;
    logic signed [W-1:0] zmin, zmax, lo, hi, px[2], py[2];
    int j, n;
    r = '0;
    n = 0;
    px[0] = 0; px[1] = 0; py[0] = 0; py[1] = 0;
    zmin = vz[0]; zmax = vz[0];
    for (int i = 1; i < 3; i++) begin
      if (vz[i] < zmin) zmin = vz[i];
      if (vz[i] > zmax) zmax = vz[i];
    end
    if (!(zmin < pz && pz < zmax)) return r;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      lo = vz[i] < vz[j] ? vz[i] : vz[j];
      hi = vz[i] > vz[j] ? vz[i] : vz[j];
      if (lo <= pz && pz < hi && n < 2) begin
        px[n] = lerp(vx[i], vx[j], vz[i], vz[j], pz);
        py[n] = lerp(vy[i], vy[j], vz[i], vz[j], pz);
        n++;
      end
    end
    r.hit = 1'b1;
    r.sx = px[0]; r.sy = py[0]; r.ex = px[1]; r.ey = py[1];
    return r;
  endfunction

  assign pending = segs_q.size();

  always @(posedge clk) begin
    logic signed [W-1:0] vx[3], vy[3], vz[3];
    seg_t want, got;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        vx = '{ax, bx, cx}; vy = '{ay, by, cy}; vz = '{az, bz, cz};
        segs_q.insert(segs_q.size(), slice(vx, vy, vz, plane_z));
      end
      if (out_valid && !out_stall) begin
        got = {hit, start_x, start_y, end_x, end_y};
        if (segs_q.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = segs_q.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected hit=%b s=(%h,%h) e=(%h,%h)", $time,
                     want.hit, want.sx, want.sy, want.ex, want.ey);
            $display("%0t:          actual   hit=%b s=(%h,%h) e=(%h,%h)", $time,
                     got.hit, got.sx, got.sy, got.ex, got.ey);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/sv/tb_triangle_plane_slice_core.sv */
module tb_triangle_plane_slice_core;
  localparam int W = tps_pkg::COORD_BITS_DEF;
  localparam int LATENCY = W + 6;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, hit;
  logic signed [W-1:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
  logic signed [W-1:0] cx = 0, cy = 0, cz = 0, plane_z = 0;
  logic signed [W-1:0] start_x, start_y, end_x, end_y;
  int errors, pending, cycles = 0;
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  triangle_plane_slice_core #(.COORD_BITS(W)) i_dut (.*);

  tps_slice_checker #(.W(W)) i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

  function automatic logic [W-1:0] coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(200) - 100;
      2: return {$urandom} >>> $urandom_range(31);
      default: return $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endcase
  endfunction

  task automatic send(logic [W-1:0] v[10]);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {ax, ay, az, bx, by, bz, cx, cy, cz, plane_z} <=
      {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9]};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    logic [W-1:0] v[10];
    int m;
    m = $urandom_range(3);
    for (int i = 0; i < 10; i++) v[i] = coord($urandom_range(9) == 0 ? 3 : m);
    case ($urandom_range(5))
      0: v[9] = v[2 + 3 * $urandom_range(2)];
      1, 2, 3: begin
        // plane halfway between the first two vertex heights (rounded down) when they differ
        if ($signed(v[2]) != $signed(v[5]))
          v[9] = ($signed(v[2]) < $signed(v[5])) ?
                 v[2] + ((v[5] - v[2]) >> 1) : v[5] + ((v[2] - v[5]) >> 1);
      end
      default: ;
    endcase
    send(v);
  endtask

  initial begin
    logic [W-1:0] MX, MN, v[10];
    MX = {1'b0, {(W-1){1'b1}}};
    MN = {1'b1, {(W-1){1'b0}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, vertex on plane, flat triangles, no hit
    v = '{MX, MN, MN, MN, MX, MX, 0, 0, 0, 0};  send(v);
    v = '{MN, MX, MX, MX, MN, MN, 5, -5, 0, 0}; send(v);
    v = '{0, 0, 0, 65536, 65536, 65536, 0, 65536, 131072, 65536}; send(v);
    v = '{0, 0, 131072, 65536, 0, 0, 3, 3, 65536, 65536}; send(v);
    v = '{1, 2, 7, 3, 4, 7, 5, 6, 7, 7};  send(v);
    v = '{1, 2, 0, 3, 4, 7, 5, 6, 9, 9};  send(v);
    v = '{1, 2, 0, 3, 4, 7, 5, 6, 9, 0};  send(v);
    v = '{1, 2, 0, 3, 4, 7, 5, 6, 9, -1}; send(v);
    v = '{MX, MX, MN, MN, MN, MX, MX, MN, 0, MX - 1}; send(v);
    v = '{MN, MN, MX, MX, MX, MN, MN, MX, 0, MN + 1}; send(v);
    v = '{-7, 9, 3, 11, -13, -3, 0, 0, 3, 0}; send(v);
    v = '{MX, MN, 1, MN, MX, 0, MX, MX, 2, 1}; send(v);
    for (int n = 0; n < 2000; n++) begin
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (LATENCY + 4) @(posedge clk);
      end
      calm = (n >= 1000 && n < 1300);
      send_random();
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

/* files.f */
rtl/tps_pkg.sv
rtl/tps_interp.sv
rtl/triangle_plane_slice_core.sv
tb/sv/tps_slice_checker.sv
tb/sv/tb_triangle_plane_slice_core.sv
